@@ hdl/sitdc_pkg.sv @@
// ----------------------------------------------------------------------------
// sitdc_pkg
// Shared types and constants for the signed integer to decimal text core.
// ----------------------------------------------------------------------------
package sitdc_pkg;

    // Requested number of decimal digit cells, clamped to 1..20 below
    localparam int DIGIT_COUNT = 10;
    localparam int DIGITS      = (DIGIT_COUNT > 20) ? 20 :
                                 ((DIGIT_COUNT < 1) ? 1 : DIGIT_COUNT);
    localparam int POS_W       = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 6;
    localparam int CNT_W       = $clog2(VALUE_W);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

    // Per-cycle command shared by every digit cell
    typedef struct packed {
        logic clear;   // zero the digit
        logic dabble;  // add-3 correction, then shift one binary bit in
        logic dshift;  // take the digit of the lower neighbor
    } cell_ctrl_t;

endpackage

@@ hdl/sitdc_cell.sv @@
// ----------------------------------------------------------------------------
// sitdc_cell
// One BCD digit of the shift-add-3 chain; also shifts whole digits upward.
// ----------------------------------------------------------------------------
module sitdc_cell
    import sitdc_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       bit_in,     // binary bit from the lower neighbor
    input  logic [3:0] digit_in,   // digit of the lower neighbor
    output logic       bit_out,    // carry bit to the upper neighbor
    output logic [3:0] digit
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    // Correct before doubling so the digit never leaves 0..9
    assign adj     = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
    assign bit_out = adj[3];
    assign digit   = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = 4'd0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adj[2:0], bit_in};
        end
        else if (ctrl.dshift)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

@@ hdl/signed_int_to_decimal_chars_core.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_chars_core
// Converts a signed 32-bit integer into its decimal ASCII text, one
// character per output transfer, most significant digit first.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata                        | tlast
//  --------+-----------+------------------------------+------------------------
//  s_axis  | in        | [31:0] value (two's compl.)  | -
//  m_axis  | out       | [5:0] character, [7:6] zero  | last character of number
//
//  Sequence: a number is accepted and converted one binary bit at a time in the
//  chain of shift-add-3 digit cells; a negative value then sends a minus sign,
//  and the digits shift out of the top cell, stepping once per digit cell (DIGITS).
//  Reset: rst_n clears the sequencer and the output valid; no clearing pass.
//  Stalls: a stalled output holds its character and freezes the digit shift;
//  the next number is taken as soon as the previous one has left the cells.
//
module signed_int_to_decimal_chars_core
    import sitdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [VALUE_W-1:0] s_axis_tdata,   // [31:0] value
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata,   // [5:0] character, [7:6] zero
    output logic               m_axis_tlast    // last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SIGN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               started_reg, started_next;
    logic               neg_reg, neg_next;
    logic [VALUE_W-1:0] mag_reg, mag_next;

    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  out_char_reg, out_char_next;
    logic               out_last_reg, out_last_next;

    cell_ctrl_t         ctrl;
    logic               accept;
    logic               out_free;
    logic               emit;
    logic [3:0]         top_digit;

    logic [3:0]         digit_w [DIGITS];
    logic               bit_w   [DIGITS+1];

    // ------------------------------------------------------------------
    // Digit cell chain: binary bits ripple upward during conversion, whole
    // digits shift upward during output.
    // ------------------------------------------------------------------
    assign bit_w[0] = mag_reg[VALUE_W-1];

    genvar gi;
    generate
        for (gi = 0; gi < DIGITS; gi++)
        begin : g_cell
            logic [3:0] lower_digit;
            if (gi == 0)
            begin : g_bottom
                assign lower_digit = 4'd0;
            end
            else
            begin : g_inner
                assign lower_digit = digit_w[gi-1];
            end
            sitdc_cell u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .bit_in   (bit_w[gi]),
                .digit_in (lower_digit),
                .bit_out  (bit_w[gi+1]),
                .digit    (digit_w[gi])
            );
        end
    endgenerate

    // Carry out of the top cell is dropped: the chain keeps the low digits
    assign top_digit = digit_w[DIGITS-1];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    // Output register can take a new character this cycle
    assign out_free      = !out_valid_reg || m_axis_tready;
    // Suppress leading zeros, but always print the units digit
    assign emit          = started_reg || (top_digit != 4'd0) || (pos_reg == '0);

    always_comb
    begin
        state_next     = state_reg;
        bit_cnt_next   = bit_cnt_reg;
        pos_next       = pos_reg;
        started_next   = started_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        ctrl           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next     = s_axis_tdata[VALUE_W-1];
                    mag_next     = s_axis_tdata[VALUE_W-1] ? (VALUE_W'(0) - s_axis_tdata)
                                                           : s_axis_tdata;
                    bit_cnt_next = '0;
                    ctrl.clear   = 1'b1;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                // Advance one binary bit through the chain
                ctrl.dabble  = 1'b1;
                mag_next     = {mag_reg[VALUE_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == CNT_W'(VALUE_W-1))
                begin
                    pos_next     = POS_W'(DIGITS-1);
                    started_next = 1'b0;
                    state_next   = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // Hold the digits while the output register is full
                if (out_free)
                begin
                    ctrl.dshift = 1'b1;
                    if (emit)
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = CHAR_ZERO + {2'b00, top_digit};
                        out_last_next  = (pos_reg == '0);
                        started_next   = 1'b1;
                    end
                    if (pos_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next = pos_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            pos_reg       <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            pos_reg       <= pos_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset
    always_ff @(posedge clk)
    begin
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_char_reg};
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // A number occupies the cells for the whole conversion
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again right after a transfer");

    // Only a minus sign or a decimal digit ever leaves the block
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[5:0] == CHAR_MINUS) ||
                          ((m_axis_tdata[5:0] >= CHAR_ZERO) &&
                           (m_axis_tdata[5:0] <= CHAR_ZERO + 6'd9)))
        else $error("output character out of range");

    // The minus sign is never the final character of a run
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[5:0] == CHAR_MINUS) |-> !m_axis_tlast)
        else $error("minus sign flagged as last");
`endif

endmodule
